// ----- rtl/mke_pkg.sv -----
// shared types, the morse table lookup and the controller state encoding
package mke_pkg;

    // longest pattern in the table, in elements
    localparam int unsigned MaxElems = 5;
    localparam int unsigned ElemCntW = 3;

    // table lookup result, pattern left-aligned so the first element sits in the top bit
    typedef struct packed {
        logic                found;
        logic [ElemCntW-1:0] len;
        logic [MaxElems-1:0] pat;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic out_free;
    } t_sts;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // fold lower case, look up the pattern (1 = dah, first element in bit len-1)
    function automatic t_entry lookup(input logic [7:0] code);
        logic [7:0]          c;
        logic [ElemCntW-1:0] len;
        logic [MaxElems-1:0] pat;
        logic                found;
        t_entry              e;
        c = code;
        if (code inside {[8'h61:8'h7A]}) begin
            c = code - 8'd32;
        end
        found = 1'b1;
        len   = '0;
        pat   = '0;
        case (c)
            8'h20: begin len = 3'd0; pat = 5'h00; end
            8'h30: begin len = 3'd5; pat = 5'h1F; end
            8'h31: begin len = 3'd5; pat = 5'h0F; end
            8'h32: begin len = 3'd5; pat = 5'h07; end
            8'h33: begin len = 3'd5; pat = 5'h03; end
            8'h34: begin len = 3'd5; pat = 5'h01; end
            8'h35: begin len = 3'd5; pat = 5'h00; end
            8'h36: begin len = 3'd5; pat = 5'h10; end
            8'h37: begin len = 3'd5; pat = 5'h18; end
            8'h38: begin len = 3'd5; pat = 5'h1C; end
            8'h39: begin len = 3'd5; pat = 5'h1E; end
            8'h41: begin len = 3'd2; pat = 5'h01; end
            8'h42: begin len = 3'd4; pat = 5'h08; end
            8'h43: begin len = 3'd4; pat = 5'h0A; end
            8'h44: begin len = 3'd3; pat = 5'h04; end
            8'h45: begin len = 3'd1; pat = 5'h00; end
            8'h46: begin len = 3'd4; pat = 5'h02; end
            8'h47: begin len = 3'd3; pat = 5'h06; end
            8'h48: begin len = 3'd4; pat = 5'h00; end
            8'h49: begin len = 3'd2; pat = 5'h00; end
            8'h4A: begin len = 3'd4; pat = 5'h07; end
            8'h4B: begin len = 3'd3; pat = 5'h05; end
            8'h4C: begin len = 3'd4; pat = 5'h04; end
            8'h4D: begin len = 3'd2; pat = 5'h03; end
            8'h4E: begin len = 3'd2; pat = 5'h02; end
            8'h4F: begin len = 3'd3; pat = 5'h07; end
            8'h50: begin len = 3'd4; pat = 5'h06; end
            8'h51: begin len = 3'd4; pat = 5'h0D; end
            8'h52: begin len = 3'd3; pat = 5'h02; end
            8'h53: begin len = 3'd3; pat = 5'h00; end
            8'h54: begin len = 3'd1; pat = 5'h01; end
            8'h55: begin len = 3'd3; pat = 5'h01; end
            8'h56: begin len = 3'd4; pat = 5'h01; end
            8'h57: begin len = 3'd3; pat = 5'h03; end
            8'h58: begin len = 3'd4; pat = 5'h09; end
            8'h59: begin len = 3'd4; pat = 5'h0B; end
            8'h5A: begin len = 3'd4; pat = 5'h0C; end
            default: begin found = 1'b0; end
        endcase
        e.found = found;
        e.len   = len;
        e.pat   = pat << (3'(MaxElems) - len);
        return e;
    endfunction

endpackage

// ----- rtl/mke_ctrl.sv -----
// controller state machine: accepts a character and sequences its keying units
module mke_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mke_pkg::t_sts  i_sts,
    output mke_pkg::t_cmd  o_cmd
);

    mke_pkg::t_state r_state;
    mke_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mke_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        case (r_state)
            mke_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mke_pkg::ST_EMIT;
                end
            end
            mke_pkg::ST_EMIT: begin
                o_cmd.step = i_sts.out_free;
                if (i_sts.out_free && i_sts.last) begin
                    n_state = mke_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mke_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/mke_datapath.sv -----
// datapath: pattern shift register, element and unit counters, output register
module mke_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_char_code,
    input  mke_pkg::t_cmd  i_cmd,
    output mke_pkg::t_sts  o_sts,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_key_on,
    output logic           o_last_unit,
    output logic           o_not_found
);

    mke_pkg::t_entry lk;

    logic [mke_pkg::MaxElems-1:0] r_pat, n_pat;
    logic [mke_pkg::ElemCntW-1:0] r_rem, n_rem;
    logic [1:0]                   r_sub, n_sub;
    logic                         r_nf, n_nf;
    logic                         r_out_valid;
    logic                         r_out_key;
    logic                         r_out_last;
    logic                         r_out_nf;
    logic                         unit_key;
    logic                         end_elem;

    assign lk = mke_pkg::lookup(i_char_code);

    // status back to the controller
    assign o_sts.last     = r_nf || (r_rem == '0);
    assign o_sts.out_free = !r_out_valid || i_ready;

    // current unit: dit is on,off and dah is on,on,on,off
    assign end_elem = r_pat[mke_pkg::MaxElems-1] ? (r_sub == 2'd3) : (r_sub == 2'd1);
    assign unit_key = !o_sts.last && !end_elem;

    // next element state
    always_comb begin
        n_pat = r_pat;
        n_rem = r_rem;
        n_sub = r_sub;
        n_nf  = r_nf;
        if (i_cmd.load) begin
            n_pat = lk.pat;
            n_rem = lk.len;
            n_sub = '0;
            n_nf  = !lk.found;
        end else if (i_cmd.step && !o_sts.last) begin
            if (end_elem) begin
                n_pat = r_pat << 1;
                n_rem = r_rem - 1'b1;
                n_sub = '0;
            end else begin
                n_sub = r_sub + 1'b1;
            end
        end
    end

    // element registers
    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
        r_rem <= n_rem;
        r_sub <= n_sub;
        r_nf  <= n_nf;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_key  <= unit_key;
            r_out_last <= o_sts.last;
            r_out_nf   <= r_nf;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_key_on    = r_out_key;
    assign o_last_unit = r_out_last;
    assign o_not_found = r_out_nf;

    // a not-found unit is a single off unit closing the character
    a_nf_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_nf |-> r_out_last && !r_out_key)
        else $error("not-found unit malformed");

    // a unit is only produced into a free output register
    a_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (!r_out_valid || i_ready))
        else $error("output overwritten");

    // the closing unit is marked last
    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && o_sts.last |=> r_out_valid && r_out_last && !r_out_key)
        else $error("closing unit not marked");

    // load and step never coincide
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && i_cmd.step))
        else $error("load and step together");

endmodule

// ----- rtl/morse_keying_encoder.sv -----
// Morse keying encoder: character requests in, keying units out, one unit per cycle
// within a character while the consumer takes them. A request is accepted while the
// controller is idle, then its units leave the output register in order: a character
// of N units (1 to 21; an unknown code or a space is 1, a digit is 11 to 21, five dahs
// the most) is walked element by element by the datapath.
// Lower case letters are folded to upper case. The final unit of each character
// has o_last_unit set; a code with no table entry gives one off unit with
// o_not_found set. The next request is taken while the last unit still waits.
module morse_keying_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_key_on,
    output logic       o_last_unit,
    output logic       o_not_found
);

    mke_pkg::t_cmd cmd;
    mke_pkg::t_sts sts;

    // sequencing
    mke_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // pattern walk and output register
    mke_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_code (i_char_code),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_key_on    (o_key_on),
        .o_last_unit (o_last_unit),
        .o_not_found (o_not_found)
    );

endmodule

// ----- tb/mke_checker.sv -----
// checker for the morse keying encoder: predicts keying units and compares them
`timescale 1ns / 1ps

module mke_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_unit_valid,
    input  logic       i_unit_ready,
    input  logic       i_key_on,
    input  logic       i_last_unit,
    input  logic       i_not_found,
    output int         o_fail_cnt,
    output int         o_pending
);

    typedef struct packed {
        logic key_on;
        logic last_unit;
        logic not_found;
    } t_unit;

    // keying units still owed by the block, oldest first
    t_unit expected_units[$];
    int    fail_cnt = 0;

    // dit/dah string for a character after case folding, 0 when not in the alphabet
    function automatic bit morse_elems(input logic [7:0] code, output string elems);
        logic [7:0] c;
        c = code;
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'd32;
        end
        morse_elems = 1'b1;
        elems = "";
        case (c)
            " ": elems = "";
            "0": elems = "-----";
            "1": elems = ".----";
            "2": elems = "..---";
            "3": elems = "...--";
            "4": elems = "....-";
            "5": elems = ".....";
            "6": elems = "-....";
            "7": elems = "--...";
            "8": elems = "---..";
            "9": elems = "----.";
            "A": elems = ".-";
            "B": elems = "-...";
            "C": elems = "-.-.";
            "D": elems = "-..";
            "E": elems = ".";
            "F": elems = "..-.";
            "G": elems = "--.";
            "H": elems = "....";
            "I": elems = "..";
            "J": elems = ".---";
            "K": elems = "-.-";
            "L": elems = ".-..";
            "M": elems = "--";
            "N": elems = "-.";
            "O": elems = "---";
            "P": elems = ".--.";
            "Q": elems = "--.-";
            "R": elems = ".-.";
            "S": elems = "...";
            "T": elems = "-";
            "U": elems = "..-";
            "V": elems = "...-";
            "W": elems = ".--";
            "X": elems = "-..-";
            "Y": elems = "-.--";
            "Z": elems = "--..";
            default: morse_elems = 1'b0;
        endcase
    endfunction

    // expand one character into its keying units
    function automatic void queue_char_units(input logic [7:0] code);
        string elems;
        int    k;
        if (!morse_elems(code, elems)) begin
            expected_units.push_back('{key_on: 1'b0, last_unit: 1'b1, not_found: 1'b1});
        end else begin
            for (k = 0; k < elems.len(); k++) begin
                expected_units.push_back('{key_on: 1'b1, last_unit: 1'b0, not_found: 1'b0});
                if (elems[k] == "-") begin
                    repeat (2) begin
                        expected_units.push_back('{key_on: 1'b1, last_unit: 1'b0,
                                                   not_found: 1'b0});
                    end
                end
                expected_units.push_back('{key_on: 1'b0, last_unit: 1'b0, not_found: 1'b0});
            end
            // character gap, also the lone unit of a space
            expected_units.push_back('{key_on: 1'b0, last_unit: 1'b1, not_found: 1'b0});
        end
    endfunction

    function automatic int field_ok(input string name, input logic exp_v, input logic act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0b, got %0b", name, exp_v, act_v);
            return 0;
        end
        return 1;
    endfunction

    // watch both channels at each edge
    always @(posedge i_clk) begin
        t_unit want;
        int    ok;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                queue_char_units(i_char_code);
            end
            if (i_unit_valid && i_unit_ready) begin
                if (expected_units.size() == 0) begin
                    $error("unexpected unit: key_on %0b last_unit %0b not_found %0b",
                           i_key_on, i_last_unit, i_not_found);
                    fail_cnt = fail_cnt + 1;
                end else begin
                    want = expected_units.pop_front();
                    ok = field_ok("key_on", want.key_on, i_key_on)
                       & field_ok("last_unit", want.last_unit, i_last_unit)
                       & field_ok("not_found", want.not_found, i_not_found);
                    if (ok == 0) begin
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
        end
        o_fail_cnt <= fail_cnt;
        o_pending  <= expected_units.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// top of the morse keying encoder testbench: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_top;

    localparam int RandItems = 100;
    localparam int IdleLimit = 3000;
    localparam int HoldCycles = 300;
    localparam int DrainCycles = 30;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_MASK
    } t_rx_mode;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_char_code = 8'h00;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_key_on;
    logic       o_last_unit;
    logic       o_not_found;

    int         fail_cnt;
    int         pending;
    logic       hold_req = 1'b0;

    morse_keying_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_key_on    (o_key_on),
        .o_last_unit (o_last_unit),
        .o_not_found (o_not_found)
    );

    mke_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_char_code  (i_char_code),
        .i_unit_valid (o_valid),
        .i_unit_ready (i_ready),
        .i_key_on     (o_key_on),
        .i_last_unit  (o_last_unit),
        .i_not_found  (o_not_found),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver stalls: mode changes now and then, one long hold-off on request
    t_rx_mode   rx_mode = RX_ALWAYS;
    int         mode_left = 40;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    logic [7:0] rx_mask = 8'b1011_0010;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 120);
            rx_mask   <= 8'($urandom_range(1, 255));
        end else begin
            mode_left <= mode_left - 1;
            rx_mask   <= {rx_mask[6:0], rx_mask[7]};
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
            i_ready   <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_ready <= 1'b1;
                RX_COIN:   i_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                default:   i_ready <= rx_mask[0];
            endcase
        end
    end

    // watchdog on cycles with no handshake on either side
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // offer one character and hold it until taken
    task automatic send_char(input logic [7:0] code);
        i_valid     <= 1'b1;
        i_char_code <= code;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic pause(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // stop offering until every owed unit has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // half letters of either case, the rest digits, spaces or any byte
    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return 8'($urandom_range(0, 255));
        end else if (r < 40) begin
            return 8'($urandom_range(8'h30, 8'h39));
        end else if (r < 68) begin
            return 8'($urandom_range(8'h41, 8'h5A));
        end else if (r < 90) begin
            return 8'($urandom_range(8'h61, 8'h7A));
        end
        return 8'h20;
    endfunction

    // directed set: extremes, space, digits, letters in both cases, codes next to the ranges
    logic [7:0] directed[] = '{
        8'h00, 8'hFF, 8'h80, 8'h7F, 8'h20, 8'h30, 8'h35, 8'h39, 8'h41, 8'h5A,
        8'h61, 8'h7A, 8'h45, 8'h54, 8'h60, 8'h7B, 8'h40, 8'h5B, 8'h2F, 8'h3A,
        8'h1F, 8'h6D, 8'h51, 8'hE1
    };

    initial begin
        int sent;
        int burst;
        int k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_char(directed[k]);
        end
        wait_drained();

        sent = 0;
        while (sent < RandItems) begin
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst && sent < RandItems; k++) begin
                send_char(random_char());
                sent++;
                // long receiver hold-off while requests keep coming
                if (sent == 30) begin
                    hold_req <= 1'b1;
                end
                if (sent == 65) begin
                    wait_drained();
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                pause($urandom_range(1, 25));
            end
        end

        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_cnt == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
